@@ hw/rtl/hrc_pkg.sv @@
// Types, constants and per-byte parsing functions for the HTTP request header checker.
`timescale 1ns / 1ps

package hrc_pkg;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_HDR   = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD     = 2'd1;
  localparam logic [1:0] STAT_NO_METH = 2'd2;
  localparam logic [1:0] STAT_NO_VER  = 2'd3;

  localparam logic [2:0] METH_OTHER = 3'd4;
  localparam logic [1:0] VER_OTHER  = 2'd2;

  localparam logic [3:0] NM_FAIL  = 4'd15;
  localparam logic [3:0] NM_HOST  = 4'd4;
  localparam logic [3:0] NM_TRAIL = 4'd5;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COLON = 8'h3a;

  localparam logic [3:0] METH_LEN [4] = '{4'd3, 4'd4, 4'd4, 4'd6};
  localparam logic [3:0] VER_LEN = 4'd8;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } hrc_item_t;

  // status in the low bits, so the packed struct is the tdata layout
  typedef struct packed {
    logic [1:0] version;
    logic [2:0] method;
    logic [1:0] status;
  } hrc_result_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       pending_cr;
    logic       line_nonempty;
    logic [2:0] token_count;
    logic       in_token;
    logic [3:0] char_position;
    logic [3:0] method_candidates;
    logic [1:0] version_candidates;
    logic [1:0] segment_count;
    logic       last_was_colon;
    logic [3:0] name_match_progress;
    logic [1:0] status_held;
    logic [2:0] method_held;
    logic [1:0] version_held;
  } hrc_state_t;

  typedef struct packed {
    hrc_state_t  st;
    logic        emit;
    hrc_result_t res;
  } hrc_step_t;

  localparam hrc_state_t ST_RESET = '{
    phase: PH_START, pending_cr: 1'b0, line_nonempty: 1'b0, token_count: 3'd0,
    in_token: 1'b0, char_position: 4'd0, method_candidates: 4'hf,
    version_candidates: 2'h3, segment_count: 2'd0, last_was_colon: 1'b0,
    name_match_progress: 4'd0, status_held: STAT_OK, method_held: METH_OTHER,
    version_held: VER_OTHER};

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9) || (c == 8'd10) || (c == 8'd11) ||
           (c == 8'd12) || (c == 8'd13);
  endfunction

  function automatic logic [7:0] method_ch(input logic [1:0] idx, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (idx)
      2'd0: begin
        case (pos)
          4'd0: ch = "G";
          4'd1: ch = "E";
          4'd2: ch = "T";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          4'd0: ch = "H";
          4'd1: ch = "E";
          4'd2: ch = "A";
          4'd3: ch = "D";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          4'd0: ch = "P";
          4'd1: ch = "O";
          4'd2: ch = "S";
          4'd3: ch = "T";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          4'd0: ch = "D";
          4'd1: ch = "E";
          4'd2: ch = "L";
          4'd3: ch = "E";
          4'd4: ch = "T";
          4'd5: ch = "E";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] version_ch(input logic idx, input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0: ch = "H";
      4'd1: ch = "T";
      4'd2: ch = "T";
      4'd3: ch = "P";
      4'd4: ch = "/";
      4'd5: ch = "1";
      4'd6: ch = ".";
      4'd7: ch = idx ? "1" : "0";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] host_ch(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0: ch = "h";
      2'd1: ch = "o";
      2'd2: ch = "s";
      default: ch = "t";
    endcase
    return ch;
  endfunction

  function automatic hrc_state_t finish_token(input hrc_state_t st);
    hrc_state_t n;
    n = st;
    if (n.token_count == 3'd1) begin
      for (int i = 0; i < 4; i++) begin
        if (METH_LEN[i] != n.char_position) n.method_candidates[i] = 1'b0;
      end
    end else if (n.token_count == 3'd3) begin
      if (n.char_position != VER_LEN) n.version_candidates = 2'b00;
    end
    n.in_token = 1'b0;
    return n;
  endfunction

  function automatic hrc_state_t content_byte(input hrc_state_t st, input logic [7:0] c);
    hrc_state_t n;
    logic [7:0] lc;
    n = st;
    lc = ((c >= 8'd65) && (c <= 8'd90)) ? (c + 8'd32) : c;
    n.line_nonempty = 1'b1;
    if (st.phase == PH_START) begin
      if (is_ws(c)) begin
        if (n.in_token) n = finish_token(n);
      end else begin
        if (!n.in_token) begin
          n.in_token = 1'b1;
          if (n.token_count < 3'd7) n.token_count = n.token_count + 3'd1;
          n.char_position = 4'd0;
        end
        if (n.token_count == 3'd1) begin
          for (int i = 0; i < 4; i++) begin
            if ((n.char_position >= METH_LEN[i]) ||
                (method_ch(2'(i), n.char_position) != c))
              n.method_candidates[i] = 1'b0;
          end
        end else if (n.token_count == 3'd3) begin
          for (int i = 0; i < 2; i++) begin
            if ((n.char_position >= VER_LEN) ||
                (version_ch(1'(i), n.char_position) != c))
              n.version_candidates[i] = 1'b0;
          end
        end
        if (n.char_position < 4'd15) n.char_position = n.char_position + 4'd1;
      end
    end else begin
      if (c == CH_COLON) begin
        if (n.segment_count < 2'd3) n.segment_count = n.segment_count + 2'd1;
        n.last_was_colon = 1'b1;
      end else begin
        n.last_was_colon = 1'b0;
        // only the name before the first colon is matched against host
        if ((n.segment_count == 2'd0) && (n.name_match_progress != NM_FAIL)) begin
          if (is_ws(c)) begin
            if (n.name_match_progress == NM_HOST)
              n.name_match_progress = NM_TRAIL;
            else if ((n.name_match_progress != 4'd0) &&
                     (n.name_match_progress != NM_TRAIL))
              n.name_match_progress = NM_FAIL;
          end else begin
            if ((n.name_match_progress < NM_HOST) &&
                (host_ch(n.name_match_progress[1:0]) == lc))
              n.name_match_progress = n.name_match_progress + 4'd1;
            else
              n.name_match_progress = NM_FAIL;
          end
        end
      end
    end
    return n;
  endfunction

  function automatic hrc_step_t end_line(input hrc_state_t st);
    hrc_step_t r;
    hrc_state_t n;
    logic [2:0] segs;
    logic host;
    n = st;
    r.emit = 1'b0;
    r.res.status = st.status_held;
    r.res.method = st.method_held;
    r.res.version = st.version_held;
    if (!n.line_nonempty) begin
      if (n.phase == PH_HDR) begin
        r.emit = 1'b1;
        n.phase = PH_DONE;
      end
    end else if (n.phase == PH_START) begin
      if (n.in_token) n = finish_token(n);
      if (n.token_count != 3'd3) begin
        n.status_held = STAT_BAD;
        n.method_held = METH_OTHER;
        n.version_held = VER_OTHER;
      end else begin
        n.method_held = METH_OTHER;
        n.version_held = VER_OTHER;
        for (int i = 0; i < 4; i++) begin
          if (n.method_candidates[i]) n.method_held = 3'(i);
        end
        for (int i = 0; i < 2; i++) begin
          if (n.version_candidates[i]) n.version_held = 2'(i);
        end
        if (n.method_held == METH_OTHER) n.status_held = STAT_NO_METH;
        else if (n.version_held == VER_OTHER) n.status_held = STAT_NO_VER;
        else n.status_held = STAT_OK;
      end
      n.phase = PH_HDR;
    end else begin
      segs = {1'b0, n.segment_count} + {2'b00, !n.last_was_colon};
      host = (n.name_match_progress == NM_HOST) || (n.name_match_progress == NM_TRAIL);
      if ((segs < 3'd2) || ((segs > 3'd2) && !host)) n.status_held = STAT_BAD;
    end
    // clear per-line state
    n.line_nonempty = 1'b0;
    n.token_count = 3'd0;
    n.in_token = 1'b0;
    n.char_position = 4'd0;
    n.method_candidates = 4'hf;
    n.version_candidates = 2'h3;
    n.segment_count = 2'd0;
    n.last_was_colon = 1'b0;
    n.name_match_progress = 4'd0;
    r.st = n;
    return r;
  endfunction

  function automatic hrc_step_t parse_step(input hrc_state_t st, input hrc_item_t item);
    hrc_step_t r;
    hrc_state_t s;
    logic [7:0] c;
    c = item.data_byte;
    s = st;
    r.st = st;
    r.emit = 1'b0;
    r.res.status = st.status_held;
    r.res.method = st.method_held;
    r.res.version = st.version_held;
    if (item.kind) begin
      r.st = ST_RESET;
    end else if (st.phase < PH_DONE) begin
      if (s.pending_cr && (c == CH_LF)) begin
        s.pending_cr = 1'b0;
        r = end_line(s);
      end else begin
        // a lone CR becomes content ahead of this byte
        if (s.pending_cr) begin
          s.pending_cr = 1'b0;
          s = content_byte(s, CH_CR);
        end
        if (c == CH_LF) begin
          r = end_line(s);
        end else if (c == CH_CR) begin
          s.pending_cr = 1'b1;
          r.st = s;
        end else begin
          r.st = content_byte(s, c);
        end
      end
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/hrc_in_stage.sv @@
// Input register: holds one accepted item until the parser takes it.
`timescale 1ns / 1ps

module hrc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hrc_pkg::hrc_item_t in_item,
  output logic              item_valid,
  output hrc_pkg::hrc_item_t item,
  input  logic              take
);

  logic              valid;
  hrc_pkg::hrc_item_t held;

  assign in_ready   = !valid || take;
  assign item_valid = valid;
  assign item       = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_item;
    end
  end

endmodule

@@ hw/rtl/hrc_parser.sv @@
// Parser state register and the per-byte update that produces results.
`timescale 1ns / 1ps

module hrc_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  hrc_pkg::hrc_item_t  item,
  input  logic                out_free,
  output logic                take,
  output logic                res_valid,
  output hrc_pkg::hrc_result_t res
);

  hrc_pkg::hrc_state_t state;
  hrc_pkg::hrc_step_t  step;

  assign take      = item_valid && out_free;
  assign step      = hrc_pkg::parse_step(state, item);
  assign res_valid = take && step.emit;
  assign res       = step.res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hrc_pkg::ST_RESET;
    end else if (take) begin
      state <= step.st;
    end
  end

endmodule

@@ hw/rtl/hrc_out_stage.sv @@
// Result register: holds one result until the sink takes it.
`timescale 1ns / 1ps

module hrc_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  hrc_pkg::hrc_result_t res,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hrc_pkg::hrc_result_t out_res
);

  logic                 valid;
  hrc_pkg::hrc_result_t held;

  assign out_free  = !valid || out_ready;
  assign out_valid = valid;
  assign out_res   = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

endmodule

@@ hw/rtl/http_request_header_checker.sv @@
// The result of a header-ending byte passes through the input register and then the result register to m_tdata.
// Throughput: one byte per cycle while no result waits on m_tready; the parser state update is a single register pass.
// A result waiting on m_tready stalls the parser; s_tready drops while the input register is full and not being taken.
// Reset (rst, synchronous) clears the parser state and both stage valid flags.
// An item with tuser set returns the parser to its reset state without a result.
`timescale 1ns / 1ps

module http_request_header_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] kind
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [1:0] status, [4:2] method, [6:5] version, [7] zero
);

  hrc_pkg::hrc_item_t   in_item;
  hrc_pkg::hrc_item_t   item;
  hrc_pkg::hrc_result_t res;
  hrc_pkg::hrc_result_t out_res;
  logic                 item_valid;
  logic                 take;
  logic                 res_valid;
  logic                 out_free;

  assign in_item.kind      = s_tuser;
  assign in_item.data_byte = s_tdata;

  hrc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  hrc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  hrc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {1'b0, out_res};

endmodule

@@ hw/rtl/hrc_checker.sv @@
// Port-level checks on the header checker's result stream, bound to the top level.
`timescale 1ns / 1ps

module hrc_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

  a_ok_codes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == 2'd0) |->
      (m_tdata[4:2] != 3'd4) && (m_tdata[6:5] != 2'd2) && (m_tdata[7] == 1'b0))
    else $error("ok status with unknown method or version");

  a_no_method: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == 2'd2) |-> (m_tdata[4:2] == 3'd4))
    else $error("not-implemented status with a known method");

  a_no_version: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == 2'd3) |->
      (m_tdata[4:2] != 3'd4) && (m_tdata[6:5] == 2'd2))
    else $error("version status with inconsistent codes");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result present right after reset");

endmodule

bind http_request_header_checker hrc_checker u_hrc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/sv/http_request_header_checker_tb.sv @@
// Self-checking stream testbench for the HTTP request header checker.
`timescale 1ns / 1ps

module http_request_header_checker_tb;
  import hrc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MIN_BYTES = 1050;

  typedef struct {
    bit         drain_first;
    hrc_item_t  item;
  } feed_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
  logic       s_tuser = 1'b0;    // [0] kind
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [1:0] status, [4:2] method, [6:5] version, [7] zero

  http_request_header_checker uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  feed_t       byte_feed [$];
  hrc_result_t expected_verdicts [$];
  feed_t       feed_head;
  hrc_result_t got, want;

  int  errors = 0;
  int  bytes_sent = 0;
  int  restarts_sent = 0;
  int  verdicts_checked = 0;
  int  drains_done = 0;
  int  requests_built = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  cycle_count = 0;
  bit  sender_burst = 1'b0;

  // parser state as the checker should hold it
  logic [1:0] p_phase;
  logic       p_cr_wait, p_line_used, p_tok_open, p_colon_last;
  logic [2:0] p_tok_count;
  logic [3:0] p_tok_len, p_host_prog, p_meth_ok;
  logic [1:0] p_ver_ok, p_colons;
  logic [1:0] p_status, p_version;
  logic [2:0] p_method;

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH at %0t: %s", $time, msg);
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd11 || c == 8'd12 ||
           c == 8'd13;
  endfunction

  function automatic string method_word(int i);
    case (i)
      0: return "GET";
      1: return "HEAD";
      2: return "POST";
      default: return "DELETE";
    endcase
  endfunction

  function automatic string version_word(int i);
    return (i == 0) ? "HTTP/1.0" : "HTTP/1.1";
  endfunction

  function automatic void clear_line_state();
    p_line_used = 1'b0;
    p_tok_count = 3'd0;
    p_tok_open = 1'b0;
    p_tok_len = 4'd0;
    p_meth_ok = 4'hf;
    p_ver_ok = 2'h3;
    p_colons = 2'd0;
    p_colon_last = 1'b0;
    p_host_prog = 4'd0;
  endfunction

  function automatic void restart_parser();
    p_phase = PH_START;
    p_cr_wait = 1'b0;
    p_status = STAT_OK;
    p_method = METH_OTHER;
    p_version = VER_OTHER;
    clear_line_state();
  endfunction

  function automatic void close_token();
    string w;
    if (p_tok_count == 3'd1) begin
      for (int i = 0; i < 4; i++) begin
        w = method_word(i);
        if (w.len() != p_tok_len) p_meth_ok[i] = 1'b0;
      end
    end else if (p_tok_count == 3'd3) begin
      if (p_tok_len != 4'd8) p_ver_ok = 2'b00;
    end
    p_tok_open = 1'b0;
  endfunction

  function automatic void take_start_char(logic [7:0] c);
    string w;
    if (is_blank(c)) begin
      if (p_tok_open) close_token();
    end else begin
      if (!p_tok_open) begin
        p_tok_open = 1'b1;
        if (p_tok_count < 3'd7) p_tok_count++;
        p_tok_len = 4'd0;
      end
      if (p_tok_count == 3'd1) begin
        for (int i = 0; i < 4; i++) begin
          w = method_word(i);
          if (p_tok_len >= w.len() || w[p_tok_len] != c) p_meth_ok[i] = 1'b0;
        end
      end else if (p_tok_count == 3'd3) begin
        for (int i = 0; i < 2; i++) begin
          w = version_word(i);
          if (p_tok_len >= 4'd8 || w[p_tok_len] != c) p_ver_ok[i] = 1'b0;
        end
      end
      if (p_tok_len < 4'd15) p_tok_len++;
    end
  endfunction

  function automatic void take_header_char(logic [7:0] c);
    logic [7:0] lc;
    string h;
    h = "host";
    if (c == CH_COLON) begin
      if (p_colons < 2'd3) p_colons++;
      p_colon_last = 1'b1;
    end else begin
      p_colon_last = 1'b0;
      // only the name ahead of the first colon can be host
      if (p_colons == 2'd0 && p_host_prog != NM_FAIL) begin
        if (is_blank(c)) begin
          if (p_host_prog == NM_HOST) p_host_prog = NM_TRAIL;
          else if (p_host_prog != 4'd0 && p_host_prog != NM_TRAIL) p_host_prog = NM_FAIL;
        end else begin
          lc = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
          if (p_host_prog < NM_HOST && h[p_host_prog] == lc) p_host_prog++;
          else p_host_prog = NM_FAIL;
        end
      end
    end
  endfunction

  function automatic void take_content(logic [7:0] c);
    p_line_used = 1'b1;
    if (p_phase == PH_START) take_start_char(c);
    else take_header_char(c);
  endfunction

  function automatic void take_line_end();
    hrc_result_t v;
    int segs;
    if (!p_line_used) begin
      if (p_phase == PH_HDR) begin
        v.status = p_status;
        v.method = p_method;
        v.version = p_version;
        expected_verdicts = {expected_verdicts, v};
        p_phase = PH_DONE;
      end
    end else if (p_phase == PH_START) begin
      if (p_tok_open) close_token();
      p_method = METH_OTHER;
      p_version = VER_OTHER;
      if (p_tok_count != 3'd3) begin
        p_status = STAT_BAD;
      end else begin
        for (int i = 0; i < 4; i++) if (p_meth_ok[i]) p_method = 3'(i);
        for (int i = 0; i < 2; i++) if (p_ver_ok[i]) p_version = 2'(i);
        if (p_method == METH_OTHER) p_status = STAT_NO_METH;
        else if (p_version == VER_OTHER) p_status = STAT_NO_VER;
        else p_status = STAT_OK;
      end
      p_phase = PH_HDR;
    end else begin
      segs = int'(p_colons) + (p_colon_last ? 0 : 1);
      if (segs < 2 || (segs > 2 && !(p_host_prog == NM_HOST || p_host_prog == NM_TRAIL)))
        p_status = STAT_BAD;
    end
    clear_line_state();
  endfunction

  function automatic void predict_parse(hrc_item_t it);
    if (it.kind) begin
      restart_parser();
      return;
    end
    if (p_phase >= PH_DONE) return;
    if (p_cr_wait) begin
      p_cr_wait = 1'b0;
      if (it.data_byte == CH_LF) begin
        take_line_end();
        return;
      end
      take_content(CH_CR);
    end
    if (it.data_byte == CH_LF) take_line_end();
    else if (it.data_byte == CH_CR) p_cr_wait = 1'b1;
    else take_content(it.data_byte);
  endfunction

  // idle lengths: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // ---------------- request byte generation ----------------

  function automatic void add_item(bit k, logic [7:0] b);
    feed_t f;
    f.drain_first = 1'b0;
    f.item.kind = k;
    f.item.data_byte = b;
    byte_feed = {byte_feed, f};
  endfunction

  function automatic void add_drain();
    feed_t f;
    f.drain_first = 1'b1;
    f.item = '0;
    byte_feed = {byte_feed, f};
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(1'b0, s[i]);
  endfunction

  function automatic string pick2(string a, string b);
    return $urandom_range(0, 1) ? a : b;
  endfunction

  function automatic void add_eol();
    if ($urandom_range(0, 1)) add_item(1'b0, CH_CR);
    add_item(1'b0, CH_LF);
  endfunction

  function automatic void add_blank_sep();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) add_item(1'b0, 8'd32);
    else if (r == 6) add_item(1'b0, 8'd9);
    else if (r == 7) add_item(1'b0, 8'd11);
    else if (r == 8) add_item(1'b0, 8'd12);
    else add_item(1'b0, CH_CR);
  endfunction

  function automatic logic [7:0] token_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) != 0) return 8'($urandom_range(33, 126));
    do c = 8'($urandom_range(0, 255)); while (is_blank(c));
    return c;
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'd9;
    if (r == 1) return 8'($urandom_range(128, 255));
    do c = 8'($urandom_range(32, 126)); while (c == CH_COLON);
    return c;
  endfunction

  function automatic void add_random_token(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) add_item(1'b0, token_char());
  endfunction

  function automatic void add_method_token();
    case ($urandom_range(0, 11))
      0, 1: add_text("GET");
      2, 3: add_text("HEAD");
      4, 5: add_text("POST");
      6, 7: add_text("DELETE");
      8: add_text(pick2("get", "Post"));
      9: add_text($urandom_range(0, 1) ? pick2("GE", "DELET") : pick2("HEADS", "GETT"));
      10: add_random_token(1, 5);
      default: add_random_token(16, 20);
    endcase
  endfunction

  function automatic void add_version_token();
    case ($urandom_range(0, 9))
      0, 1, 2: add_text("HTTP/1.0");
      3, 4, 5: add_text("HTTP/1.1");
      6: add_text(pick2("HTTP/1.2", "HTTP/2.0"));
      7: add_text(pick2("HTTP/1", "HTTP/1.10"));
      8: add_text(pick2("http/1.1", "HTTP-1.1"));
      default: add_random_token(1, 10);
    endcase
  endfunction

  function automatic void add_start_line();
    int r;
    int ntok;
    r = $urandom_range(0, 19);
    ntok = (r < 16) ? 3 : (r == 16) ? 1 : (r == 17) ? 2 : (r == 18) ? 4 : 9;
    if ($urandom_range(0, 5) == 0) add_blank_sep();
    for (int t = 1; t <= ntok; t++) begin
      if (t > 1) begin
        add_blank_sep();
        if ($urandom_range(0, 4) == 0) add_blank_sep();
      end
      if (t == 1) add_method_token();
      else if (t == 3) add_version_token();
      else if ($urandom_range(0, 7) == 0) add_text("*");
      else begin
        add_text("/");
        add_random_token(0, 3);
      end
    end
    if ($urandom_range(0, 5) == 0) add_blank_sep();
    add_eol();
  endfunction

  function automatic void add_header_line();
    int r;
    int colons;
    case ($urandom_range(0, 9))
      0, 1: add_text("Host");
      2: add_text("host");
      3: begin
        add_text(" hOsT");
        add_item(1'b0, 8'd9);
      end
      4: add_text(pick2("Hos", "Hostx"));
      5: add_text(pick2("ho st", "h"));
      6: add_text("Accept");
      7: add_text("X-Id");
      8: add_random_token(1, 6);
      default: ;
    endcase
    r = $urandom_range(0, 19);
    colons = (r < 2) ? 0 : (r < 14) ? 1 : (r < 17) ? 2 : $urandom_range(3, 4);
    for (int i = 0; i < colons; i++) begin
      add_item(1'b0, CH_COLON);
      repeat ($urandom_range(0, 4)) add_item(1'b0, value_char());
    end
    if ($urandom_range(0, 9) == 0) add_item(1'b0, CH_COLON);
    add_eol();
  endfunction

  function automatic void add_request();
    int nhdr;
    add_item(1'b1, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) add_eol();
    add_start_line();
    nhdr = $urandom_range(0, 2);
    for (int i = 0; i < nhdr; i++) begin
      add_header_line();
      // drop the rest now and then; the next restart cuts the request short
      if ($urandom_range(0, 24) == 0) return;
    end
    add_eol();
    requests_built++;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) add_item(1'b0, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_noise();
    add_item(1'b1, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(3, 12)) add_item(1'b0, 8'($urandom_range(0, 255)));
  endfunction

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
      restart_parser();
    end else begin
      if (s_tvalid && s_tready) begin
        predict_parse('{kind: s_tuser, data_byte: s_tdata});
        bytes_sent++;
        if (s_tuser) restarts_sent++;
      end
      if (s_tvalid && !s_tready) begin
        // hold the item until it is taken
      end else if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (byte_feed.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (byte_feed[0].drain_first) begin
        s_tvalid <= 1'b0;
        if (expected_verdicts.size() == 0) begin
          void'(byte_feed.pop_front());
          drains_done++;
        end
      end else begin
        feed_head = byte_feed.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= feed_head.item.data_byte;
        s_tuser <= feed_head.item.kind;
        if (feed_head.item.kind) sender_burst <= ($urandom_range(0, 3) == 0);
        gap_left <= sender_burst ? 0 : pick_gap();
      end
    end
  end

  // ---------------- monitor and receiver ----------------

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[6:0];
        if (expected_verdicts.size() == 0) begin
          note_error($sformatf("verdict 0x%02h with none expected", m_tdata));
        end else begin
          want = expected_verdicts.pop_front();
          if (got.status != want.status)
            note_error($sformatf("status expected %0d got %0d", want.status, got.status));
          if (got.method != want.method)
            note_error($sformatf("method expected %0d got %0d", want.method, got.method));
          if (got.version != want.version)
            note_error($sformatf("version expected %0d got %0d", want.version, got.version));
          verdicts_checked++;
        end
      end
      if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready <= 1'b1;
        // leave one stretch in four free of stalls
        if (cycle_count[9:8] != 2'b00 && $urandom_range(0, 4) == 0) stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               expected_verdicts.size());
      $display("http_request_header_checker_tb: done, errors");
      $finish;
    end
  end

  // ---------------- stimulus and end of run ----------------

  initial begin
    // restart, skipped CRLF and LF lines, lone CR between tokens, then bytes past the end
    add_item(1'b1, 8'hff);
    add_item(1'b0, CH_CR);
    add_item(1'b0, CH_LF);
    add_item(1'b0, CH_LF);
    add_text("GET");
    add_item(1'b0, CH_CR);
    add_text("a HTTP/1.1");
    add_item(1'b0, CH_LF);
    add_item(1'b0, CH_LF);
    add_item(1'b0, 8'h00);
    add_item(1'b0, 8'hff);
    add_drain();

    while (byte_feed.size() < MIN_BYTES) begin
      if ($urandom_range(0, 19) == 0) add_noise();
      else add_request();
      if ($urandom_range(0, 9) == 0) add_drain();
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (byte_feed.size() != 0 || s_tvalid);
    do @(posedge clk); while (expected_verdicts.size() != 0);
    repeat (20) @(posedge clk);

    if (expected_verdicts.size() != 0)
      note_error($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
    $display("sent %0d bytes over %0d restarts, %0d full requests, %0d drain pauses",
             bytes_sent, restarts_sent, requests_built, drains_done);
    $display("checked %0d header verdicts, %0d mismatches", verdicts_checked, errors);
    if (errors == 0) begin
      $display("http_request_header_checker_tb: done, clean");
    end else begin
      $display("http_request_header_checker_tb: done, errors");
    end
    $finish;
  end

endmodule
